[hdl/srb_pkg.sv]
// shared types and constants for the sequence reorder buffer
`timescale 1ns / 1ps

package srb_pkg;

	// reorder window, a power of two so that the slot is the low bits of the number
	localparam int WINDOW = 32;
	localparam int SLOT_W = $clog2(WINDOW);

	localparam int NUM_W = 32;
	localparam int LEN_W = 16;
	localparam int HANDLE_W = 32;
	localparam int ENTRY_W = LEN_W + HANDLE_W;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// result status codes
	localparam logic [1:0] STATUS_RELEASED = 2'd0;
	localparam logic [1:0] STATUS_LATE = 2'd1;
	localparam logic [1:0] STATUS_AHEAD = 2'd2;

	// one queued request with its slot already worked out
	typedef struct packed {
		logic [NUM_W-1:0] number;
		logic [LEN_W-1:0] length;
		logic [HANDLE_W-1:0] handle;
		logic [SLOT_W-1:0] slot;
	} item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT
	} back_state_t;

endpackage

[hdl/srb_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps

module srb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/srb_front.sv]
// front end: accepts requests, works out the slot and queues them
`timescale 1ns / 1ps

module srb_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        frame_valid,
	output logic                        frame_ready,
	input  logic [srb_pkg::NUM_W-1:0]    frame_number,
	input  logic [srb_pkg::LEN_W-1:0]    frame_length,
	input  logic [srb_pkg::HANDLE_W-1:0] buffer_handle,
	output logic                        q_valid,
	output srb_pkg::item_t              q_item,
	input  logic                        q_pop
);

	import srb_pkg::*;

	item_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	item_t             new_item;

	assign frame_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push = frame_valid && frame_ready;

	always_comb begin
		new_item.number = frame_number;
		new_item.length = frame_length;
		new_item.handle = buffer_handle;
		new_item.slot = frame_number[SLOT_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !q_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (!push && q_pop) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	assign q_valid = (count_q != '0);
	assign q_item = entry_q[rd_ptr_q];

endmodule

[hdl/srb_back.sv]
// back end: window check, slot store and in-order release sequencer
`timescale 1ns / 1ps

module srb_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  srb_pkg::item_t              q_item,
	output logic                        q_pop,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [srb_pkg::NUM_W-1:0]    out_frame_number,
	output logic [srb_pkg::LEN_W-1:0]    out_length,
	output logic [srb_pkg::HANDLE_W-1:0] out_handle,
	output logic [1:0]                  status,
	output logic                        last_of_run
);

	import srb_pkg::*;

	back_state_t         state_q;
	back_state_t         state_d;
	logic [NUM_W-1:0]    next_exp_q;
	logic [WINDOW-1:0]   valid_q;

	logic [NUM_W-1:0]    offset;
	logic                is_late;
	logic                is_ahead;
	logic                drop;
	logic [SLOT_W-1:0]   ne_slot;
	logic [SLOT_W-1:0]   ne1_slot;
	logic                out_free;

	logic                store;
	logic                ram_re;
	logic                emit;
	logic                drop_load;
	logic [ENTRY_W-1:0]  ram_rdata;

	logic                out_valid_q;
	logic [NUM_W-1:0]    out_number_q;
	logic [LEN_W-1:0]    out_length_q;
	logic [HANDLE_W-1:0] out_handle_q;
	logic [1:0]          out_status_q;
	logic                out_last_q;

	// window classification against the expected number
	assign offset = q_item.number - next_exp_q;
	assign is_late = offset[NUM_W-1];
	assign is_ahead = !is_late && (offset >= NUM_W'(WINDOW));
	assign drop = is_late || is_ahead;

	assign ne_slot = next_exp_q[SLOT_W-1:0];
	assign ne1_slot = ne_slot + SLOT_W'(1);
	assign out_free = !out_valid_q || result_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid && !drop) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (valid_q[ne_slot]) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_READ;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		store = 1'b0;
		drop_load = 1'b0;
		ram_re = 1'b0;
		emit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				store = q_valid && !drop;
				drop_load = q_valid && drop && out_free;
			end
			ST_READ: begin
				ram_re = valid_q[ne_slot];
			end
			ST_EMIT: begin
				emit = out_free;
			end
			default: ;
		endcase
		q_pop = store || drop_load;
	end

	srb_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (WINDOW)
	) u_slot_ram (
		.clk   (clk),
		.we    (store),
		.waddr (q_item.slot),
		.wdata ({q_item.length, q_item.handle}),
		.re    (ram_re),
		.raddr (ne_slot),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			next_exp_q <= '0;
			valid_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (store) begin
				valid_q[q_item.slot] <= 1'b1;
			end
			if (emit) begin
				valid_q[ne_slot] <= 1'b0;
				next_exp_q <= next_exp_q + NUM_W'(1);
			end
			if (emit || drop_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_number_q <= next_exp_q;
			out_length_q <= ram_rdata[ENTRY_W-1:HANDLE_W];
			out_handle_q <= ram_rdata[HANDLE_W-1:0];
			out_status_q <= STATUS_RELEASED;
			out_last_q <= !valid_q[ne1_slot];
		end else if (drop_load) begin
			out_number_q <= q_item.number;
			out_length_q <= q_item.length;
			out_handle_q <= q_item.handle;
			out_status_q <= is_late ? STATUS_LATE : STATUS_AHEAD;
			out_last_q <= 1'b1;
		end
	end

	assign result_valid = out_valid_q;
	assign out_frame_number = out_number_q;
	assign out_length = out_length_q;
	assign out_handle = out_handle_q;
	assign status = out_status_q;
	assign last_of_run = out_last_q;

endmodule

[hdl/sequence_reorder_buffer.sv]
// top level of the sequence reorder buffer
`timescale 1ns / 1ps

// frame descriptors arrive on the frame channel in any order and leave on the
// result channel in sequence order, starting from frame number zero after reset.
// a frame within 32 numbers ahead of the expected one is parked in its slot
// (number mod 32); a repeat of a parked number overwrites it. whenever the
// expected frame is present it goes out together with every consecutive parked
// frame, and last_of_run marks the final one released by that request. a frame
// behind the expected number, or 32 or more ahead, comes straight back with
// status late or ahead and last_of_run set, and changes nothing. a frame that
// only fills a gap further on produces no result. a two-deep request queue
// decouples the input from the slot sequencer, so the input can take two
// requests while results stall. the sequencer checks and stores each request
// in its idle state, then releases each frame in two steps as the slot ram
// read is registered (valid check with ram read, then load of the result
// register once it is free) and closes the run with a failing valid check.
// a dropped frame loads the result register from idle once it is free. there
// is no reset sweep: slot valid bits are flip-flops cleared by reset.

module sequence_reorder_buffer (
	input  logic                        clk,
	input  logic                        arst_n,
	// request channel
	input  logic                        frame_valid,
	output logic                        frame_ready,
	input  logic [srb_pkg::NUM_W-1:0]    frame_number,
	input  logic [srb_pkg::LEN_W-1:0]    frame_length,
	input  logic [srb_pkg::HANDLE_W-1:0] buffer_handle,
	// result channel
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [srb_pkg::NUM_W-1:0]    out_frame_number,
	output logic [srb_pkg::LEN_W-1:0]    out_length,
	output logic [srb_pkg::HANDLE_W-1:0] out_handle,
	output logic [1:0]                  status,
	output logic                        last_of_run
);

	import srb_pkg::*;

	// queue between front and back
	logic  q_valid;
	item_t q_item;
	logic  q_pop;

	// front end: takes requests and tags each with its slot
	srb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.frame_valid   (frame_valid),
		.frame_ready   (frame_ready),
		.frame_number  (frame_number),
		.frame_length  (frame_length),
		.buffer_handle (buffer_handle),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	// back end: window check, slot store, in-order release, result register
	srb_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_valid          (q_valid),
		.q_item           (q_item),
		.q_pop            (q_pop),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.out_frame_number (out_frame_number),
		.out_length       (out_length),
		.out_handle       (out_handle),
		.status           (status),
		.last_of_run      (last_of_run)
	);

endmodule
